// ===== src/av_sync_master_clock_macros.svh =====
// assertion macros for the av sync master clock
// uses clk and rst_n of the module that expands them
`ifndef AV_SYNC_MASTER_CLOCK_MACROS_SVH
`define AV_SYNC_MASTER_CLOCK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AVS_ASSERT_IMP(lbl, ante, cons, msg)
`define AVS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/avs_pkg.sv =====
// shared types, constants and helpers of the av sync master clock
// no dependencies
package avs_pkg;

  localparam int TIME_W  = 40;
  localparam int OFF_W   = 48;
  localparam int RATE_W  = 11;
  localparam int SCL_W   = 43;
  localparam int DVD_W   = 49;
  localparam int CNT_W   = 6;
  localparam int IN_W    = 296;
  localparam int OUT_W   = 64;

  localparam logic [RATE_W-1:0] RATE_ONE = 11'd256;
  localparam logic [RATE_W-1:0] RATE_MIN = 11'd64;
  localparam logic [RATE_W-1:0] RATE_MAX = 11'd1024;
  localparam logic [23:0] TIMEOUT_RST = 24'd1500000;
  localparam logic [19:0] MAXD_RST    = 20'd200000;
  localparam logic [23:0] MIN_THR     = 24'd10000;
  localparam logic [40:0] WRAP_INTV   = 41'd1000000;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd48;

  typedef enum logic [2:0] {
    OP_DELAY  = 3'd0,
    OP_SEEK   = 3'd1,
    OP_ALIGN  = 3'd2,
    OP_FREEZE = 3'd3,
    OP_RESUME = 3'd4,
    OP_SPEED  = 3'd5,
    OP_PAUSE  = 3'd6,
    OP_RESET  = 3'd7
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_MAXD    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MS_PLAYED  = 2'd0,
    MS_B       = 2'd1,
    MS_ELAPSED = 2'd2,
    MS_LASTDLY = 2'd3
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE_P, S_PRE_B, S_PRE_L, S_ACT, S_POST_L, S_POST_P,
    S_MASTER, S_DLY_M, S_DLY_N, S_DIV, S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic     latch_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     act;
    logic     master;
    logic     dly_load;
    logic     div_step;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    out_busy;
  } ctl_sts_t;

  // wall time since then, backward time counts as zero
  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                input logic [TIME_W-1:0] then);
    logic [TIME_W-1:0] d;
    d = now - then;
    return d[TIME_W-1] ? '0 : d;
  endfunction

endpackage

// ===== src/avs_ctl.sv =====
// sequencer of the av sync master clock: steps one event through the datapath
// depends on avs_pkg
module avs_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  avs_pkg::ctl_sts_t sts,
  output avs_pkg::ctl_cmd_t cmd
);
  import avs_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DLY_N) cnt_r <= '0;
      else if (state_r == S_DIV) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_PRE_P;
      S_PRE_P:  state_nxt = S_PRE_B;
      S_PRE_B:  state_nxt = S_PRE_L;
      S_PRE_L:  state_nxt = S_ACT;
      S_ACT:    state_nxt = S_POST_L;
      S_POST_L: state_nxt = S_POST_P;
      S_POST_P: state_nxt = S_MASTER;
      S_MASTER: state_nxt = (sts.op == OP_DELAY) ? S_DLY_M : S_DONE;
      S_DLY_M:  state_nxt = S_DLY_N;
      S_DLY_N:  state_nxt = S_DIV;
      S_DIV:    if (cnt_r == DIV_LAST) state_nxt = S_DONE;
      S_DONE:   if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.latch_in = in_tvalid;
      end
      S_PRE_P, S_POST_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PLAYED;
      end
      S_PRE_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_B;
      end
      S_PRE_L, S_POST_L: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ELAPSED;
      end
      S_ACT:    cmd.act = 1'b1;
      S_MASTER: cmd.master = 1'b1;
      S_DLY_M: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LASTDLY;
      end
      S_DLY_N:  cmd.dly_load = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_DONE:   cmd.out_load = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== src/avs_dp.sv =====
// datapath of the av sync master clock: clock state, shared multiplier,
// bit-serial divider and output register; depends on avs_pkg and the macros
`include "av_sync_master_clock_macros.svh"
module avs_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [avs_pkg::IN_W-1:0]   in_tdata,
  input  logic [2:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [avs_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [23:0]                cfg_wdata,
  input  avs_pkg::ctl_cmd_t          cmd,
  output avs_pkg::ctl_sts_t          sts
);
  import avs_pkg::*;

  // event operands
  opcode_t           op_r;
  logic [TIME_W-1:0] now_r, val_r, lpts_r, played_r, written_r;
  logic [23:0]       ldly_r, fdur_r;
  logic [31:0]       gen_r;
  logic              act_r, pflag_r;
  logic [11:0]       speed_r;

  // clock state
  logic [OFF_W-1:0]  off_r;
  logic              pend_r, fb_r, paused_r;
  logic [TIME_W-1:0] ppos_r, fstart_r, lbase_r, lanch_r;
  logic [31:0]       pgen_r;
  logic [RATE_W-1:0] rate_r;
  logic [23:0]       timeout_r;
  logic [19:0]       maxd_r;

  // products and results
  logic [SCL_W-1:0]  pa_r, pb_r, pl_r;
  logic [26:0]       ld_r;
  logic [TIME_W-1:0] master_r;
  logic              acc_r, fell_r;
  logic [DVD_W-1:0]  dq_r;
  logic [RATE_W-1:0] rem_r;
  logic              out_valid_r;
  logic [19:0]       odly_r;
  logic [TIME_W-1:0] omaster_r;
  logic              oacc_r, ofell_r;

  // shared multiplier
  logic [TIME_W-1:0]        mul_a;
  logic [RATE_W-1:0]        mul_b, spd_c;
  logic [TIME_W+RATE_W-1:0] prod;
  logic [SCL_W-1:0]         mul_res;

  always_comb begin
    if (speed_r < {1'b0, RATE_MIN}) spd_c = RATE_MIN;
    else if (speed_r > {1'b0, RATE_MAX}) spd_c = RATE_MAX;
    else spd_c = speed_r[RATE_W-1:0];
  end

  always_comb begin
    mul_a = played_r;
    mul_b = rate_r;
    unique case (cmd.mul_sel)
      MS_PLAYED: begin
        mul_a = played_r;
        mul_b = rate_r;
      end
      MS_B: begin
        mul_a = (op_r == OP_RESUME) ? written_r : played_r;
        mul_b = (op_r == OP_RESUME) ? rate_r : spd_c;
      end
      MS_ELAPSED: begin
        mul_a = elapsed(now_r, lanch_r);
        mul_b = rate_r;
      end
      MS_LASTDLY: begin
        mul_a = {16'b0, ldly_r};
        mul_b = rate_r;
      end
      default: begin
        mul_a = played_r;
        mul_b = rate_r;
      end
    endcase
  end

  assign prod    = {{RATE_W{1'b0}}, mul_a} * {{TIME_W{1'b0}}, mul_b};
  assign mul_res = prod[TIME_W+RATE_W-1:8];

  // local clock, held while paused
  logic [TIME_W-1:0] loc;
  assign loc = paused_r ? lbase_r : lbase_r + pl_r[TIME_W-1:0];

  logic [OFF_W-1:0] val48, off_pa, off_pb, off_spd;
  assign val48   = {{(OFF_W-TIME_W){val_r[TIME_W-1]}}, val_r};
  assign off_pa  = val48 - {5'b0, pa_r};
  assign off_pb  = val48 - {5'b0, pb_r};
  assign off_spd = off_r + {5'b0, pa_r} - {5'b0, pb_r};

  logic timed_out, gen_match;
  assign timed_out = elapsed(now_r, fstart_r) > {16'b0, timeout_r};
  assign gen_match = pend_r && (gen_r == pgen_r);

  // delay query numerator
  logic [40:0] intv41, diff41;
  logic [41:0] intv42, diff42, thr42, sum42, num42;
  logic [23:0] thr24;
  logic        bad_intv;
  logic [DVD_W-1:0] dvd;

  always_comb begin
    intv41   = {val_r[TIME_W-1], val_r} - {lpts_r[TIME_W-1], lpts_r};
    bad_intv = intv41[40] || (intv41 == '0) || (intv41 >= WRAP_INTV);
    if (!bad_intv) intv42 = {intv41[40], intv41};
    else if (ldly_r != '0) intv42 = {15'b0, ld_r};
    else intv42 = {18'b0, fdur_r};
    diff41 = {val_r[TIME_W-1], val_r} - {master_r[TIME_W-1], master_r};
    diff42 = {diff41[40], diff41};
    thr24  = (fdur_r > MIN_THR) ? fdur_r : MIN_THR;
    thr42  = {18'b0, thr24};
    sum42  = intv42 + diff42;
    if ($signed(diff42) <= -$signed(thr42)) num42 = '0;
    else if ($signed(diff42) >= $signed(thr42)) num42 = diff42;
    else num42 = sum42;
    dvd = ($signed(num42) > 0) ? {num42[40:0], 8'b0} : '0;
  end

  // one quotient bit a step
  logic [RATE_W:0] rem_s, rem_d;
  logic            q_bit;
  assign rem_s = {rem_r, dq_r[DVD_W-1]};
  assign q_bit = rem_s >= {1'b0, rate_r};
  assign rem_d = q_bit ? rem_s - {1'b0, rate_r} : rem_s;

  logic [19:0] dly_c;
  assign dly_c = (op_r != OP_DELAY) ? '0 :
                 (dq_r > {29'b0, maxd_r}) ? maxd_r : dq_r[19:0];

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r      <= opcode_t'(in_tuser);
      now_r     <= in_tdata[39:0];
      val_r     <= in_tdata[79:40];
      lpts_r    <= in_tdata[119:80];
      ldly_r    <= in_tdata[143:120];
      fdur_r    <= in_tdata[167:144];
      gen_r     <= in_tdata[199:168];
      act_r     <= in_tdata[200];
      played_r  <= in_tdata[240:201];
      written_r <= in_tdata[280:241];
      speed_r   <= in_tdata[292:281];
      pflag_r   <= in_tdata[293];
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MS_PLAYED:  pa_r <= mul_res;
        MS_B:       pb_r <= mul_res;
        MS_ELAPSED: pl_r <= mul_res;
        MS_LASTDLY: ld_r <= mul_res[26:0];
        default:    pa_r <= mul_res;
      endcase
    end
    if (cmd.dly_load) begin
      dq_r  <= dvd;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[DVD_W-2:0], q_bit};
      rem_r <= rem_d[RATE_W-1:0];
    end
    if (cmd.out_load) begin
      odly_r    <= dly_c;
      omaster_r <= master_r;
      oacc_r    <= acc_r;
      ofell_r   <= fell_r;
    end
  end

  // clock state and event flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      pend_r      <= 1'b0;
      fb_r        <= 1'b0;
      ppos_r      <= '0;
      pgen_r      <= '0;
      fstart_r    <= '0;
      lbase_r     <= '0;
      lanch_r     <= '0;
      rate_r      <= RATE_ONE;
      paused_r    <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      maxd_r      <= MAXD_RST;
      acc_r       <= 1'b0;
      fell_r      <= 1'b0;
      out_valid_r <= 1'b0;
      master_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TIMEOUT: timeout_r <= cfg_wdata;
          CFG_MAXD:    maxd_r <= cfg_wdata[19:0];
          default:     timeout_r <= cfg_wdata;
        endcase
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cmd.latch_in) begin
        acc_r  <= 1'b0;
        fell_r <= 1'b0;
      end
      if (cmd.act) begin
        unique case (op_r)
          OP_DELAY: ;
          OP_SEEK: begin
            if (act_r) off_r <= off_pa;
            lbase_r <= val_r;
            lanch_r <= now_r;
          end
          OP_ALIGN: begin
            if (act_r) off_r <= off_pa;
            else begin
              lbase_r <= val_r;
              lanch_r <= now_r;
            end
          end
          OP_FREEZE: begin
            pend_r   <= 1'b1;
            fb_r     <= 1'b0;
            ppos_r   <= val_r;
            pgen_r   <= gen_r;
            fstart_r <= now_r;
          end
          OP_RESUME: begin
            if (gen_match) begin
              pend_r <= 1'b0;
              fb_r   <= 1'b0;
              acc_r  <= 1'b1;
              if (act_r) off_r <= off_pb;
              else begin
                lbase_r <= val_r;
                lanch_r <= now_r;
              end
            end
          end
          OP_SPEED: begin
            if (act_r) off_r <= off_spd;
            lbase_r <= loc;
            lanch_r <= now_r;
            rate_r  <= spd_c;
          end
          OP_PAUSE: begin
            if (pflag_r) begin
              lbase_r  <= loc;
              paused_r <= 1'b1;
            end else begin
              paused_r <= 1'b0;
            end
            lanch_r <= now_r;
          end
          OP_RESET: begin
            off_r   <= '0;
            pend_r  <= 1'b0;
            fb_r    <= 1'b0;
            lbase_r <= '0;
            lanch_r <= now_r;
          end
          default: ;
        endcase
      end
      if (cmd.master) begin
        if (!act_r) master_r <= loc;
        else if (pend_r) begin
          master_r <= ppos_r;
          // audio start never came: restart the local clock at the frozen spot
          if (timed_out) begin
            pend_r  <= 1'b0;
            fb_r    <= 1'b1;
            lbase_r <= ppos_r;
            lanch_r <= now_r;
            fell_r  <= 1'b1;
          end
        end else if (fb_r) master_r <= loc;
        else master_r <= pa_r[TIME_W-1:0] + off_r[TIME_W-1:0];
      end
    end
  end

  assign sts.op       = op_r;
  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {2'b0, ofell_r, oacc_r, omaster_r, odly_r};

  `AVS_ASSERT_IMP(a_rate_range, 1'b1, (rate_r >= RATE_MIN) && (rate_r <= RATE_MAX), "rate out of range")
  `AVS_ASSERT_IMP(a_pend_fb, 1'b1, !(pend_r && fb_r), "pending and fallback both set")
  `AVS_ASSERT_IMP(a_out_free, cmd.out_load, !out_valid_r || out_tready, "output overwritten")
  `AVS_ASSERT_IMP(a_fell_active, cmd.out_load && fell_r, act_r, "fallback without audio")
  `AVS_ASSERT_NXT(a_acc_resume, cmd.act && (op_r != OP_RESUME), !acc_r, "accept on other opcode")

endmodule

// ===== src/av_sync_master_clock.sv =====
// top level of the audio-master av sync clock
// depends on avs_pkg, avs_ctl and avs_dp
//
//  channel  direction  handshake                 payload
//  in_      input      in_tvalid / in_tready     in_tdata, in_tuser (opcode)
//  out_     output     out_tvalid / out_tready   out_tdata
//  cfg_     input      cfg_we                    cfg_index, cfg_wdata
//
// one event at a time: it is latched, the products formed, the event applied and
// the master time found; a delay query then runs the bit-serial divider by rate
// the result sits in an output register, so the next event is taken while it waits
// reset (rst_n low, synchronous) restores the register defaults and the clock state
module av_sync_master_clock (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // now_us, value_us, last_pts_us, last_delay_us, frame_duration_us, generation,
  // audio_active, played_us, written_us, speed_q8, pause_flag, pad
  input  logic [avs_pkg::IN_W-1:0]  in_tdata,
  // opcode
  input  logic [2:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // delay_us, master_us, accepted, fell_back, pad
  output logic [avs_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [23:0]               cfg_wdata
);
  import avs_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  avs_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  avs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
